// File: rtl/rcbi_pkg.sv
// ----------------------------------------------------------------------------
// rcbi_pkg
// Shared types and constants of the row cutter: register indexes, the
// blockage table entry and the sequencer states.
// ----------------------------------------------------------------------------
package rcbi_pkg;

    localparam int CoordW = 32;
    localparam int PitchW = 16;
    localparam int IdxW   = 6;
    localparam int CfgIdxW = 3;
    // remainder bits retired per cycle in the snap unit
    localparam int ModStep = 4;

    localparam logic [CfgIdxW-1:0] REG_ROW_LEFT    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ROW_RIGHT   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_ROW_BOTTOM  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_ROW_TOP     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_GRID_ORIGIN = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SITE_PITCH  = 3'd5;

    typedef struct packed {
        logic signed [CoordW-1:0] lo;
        logic signed [CoordW-1:0] hi;
    } blk_t;

    typedef struct packed {
        logic signed [CoordW-1:0] seg_start;
        logic signed [CoordW-1:0] seg_end;
        logic [IdxW-1:0]          seg_index;
        logic                     row_empty;
    } seg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SNAP,
        ST_CLIP,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_SW_RD,
        ST_SW_CHK,
        ST_SW_TAIL,
        ST_FIN
    } state_t;

endpackage

// File: rtl/rcbi_ram.sv
// ----------------------------------------------------------------------------
// rcbi_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module rcbi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/rcbi_modu.sv
// ----------------------------------------------------------------------------
// rcbi_modu
// Multi-cycle floor remainder of two signed offsets by the site pitch,
// ModStep bits per cycle, both offsets in parallel.
// ----------------------------------------------------------------------------
module rcbi_modu import rcbi_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [CoordW+1:0] dl,
    input  logic signed [CoordW+1:0] dr,
    input  logic [PitchW-1:0]        pitch,
    output logic                     done,
    output logic [PitchW-1:0]        rl,
    output logic [PitchW-1:0]        rr
);

    localparam int Steps = CoordW / ModStep;
    localparam int CntW  = $clog2(Steps);

    logic [CoordW-1:0] ml_reg, ml_next, mr_reg, mr_next;
    logic [PitchW-1:0] reml_reg, reml_next, remr_reg, remr_next, p_reg;
    logic              negl_reg, negr_reg;
    logic [CntW-1:0]   cnt_reg;
    logic              busy_reg, done_reg;
    logic [CoordW+1:0] absl, absr;

    assign absl = dl[CoordW+1] ? -dl : dl;
    assign absr = dr[CoordW+1] ? -dr : dr;

    // restoring remainder, ModStep bits of the dividend per cycle
    always_comb
    begin
        logic [PitchW:0] t;
        ml_next   = ml_reg;
        mr_next   = mr_reg;
        reml_next = reml_reg;
        remr_next = remr_reg;
        for (int k = 0; k < ModStep; k++)
        begin
            t = {reml_next, ml_next[CoordW-1]};
            if (t >= {1'b0, p_reg})
            begin
                t = t - {1'b0, p_reg};
            end
            reml_next = t[PitchW-1:0];
            ml_next   = ml_next << 1;
            t = {remr_next, mr_next[CoordW-1]};
            if (t >= {1'b0, p_reg})
            begin
                t = t - {1'b0, p_reg};
            end
            remr_next = t[PitchW-1:0];
            mr_next   = mr_next << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(Steps - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ml_reg   <= absl[CoordW-1:0];
            mr_reg   <= absr[CoordW-1:0];
            reml_reg <= '0;
            remr_reg <= '0;
            negl_reg <= dl[CoordW+1];
            negr_reg <= dr[CoordW+1];
            p_reg    <= (pitch == '0) ? PitchW'(1) : pitch;
        end
        else if (busy_reg)
        begin
            ml_reg   <= ml_next;
            mr_reg   <= mr_next;
            reml_reg <= reml_next;
            remr_reg <= remr_next;
        end
    end

    // negative offset with a remainder folds to the floor remainder
    assign rl   = (negl_reg && reml_reg != '0) ? p_reg - reml_reg : reml_reg;
    assign rr   = (negr_reg && remr_reg != '0) ? p_reg - remr_reg : remr_reg;
    assign done = done_reg;

endmodule

// File: rtl/row_cut_by_blockage_intervals.sv
// ----------------------------------------------------------------------------
// row_cut_by_blockage_intervals
// Collects snapped and clipped macro halo blockages of one row in a sorted
// table memory and, on the last item, sweeps it to emit the free segments.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  cfg     | cfg_we, cfg_index, cfg_wdata              | write when cfg_we
//  in      | halo_*, has_macro, last_macro             | in_valid / in_ready
//  out     | seg_*, row_empty, dropped, last_seg       | out_valid / out_ready
//
//  an item with no overlapping rectangle needs only the idle state; one that
//  overlaps waits in the snap state for the remainder unit, then is clipped;
//  an insert into a non-empty table moves each larger entry up, from the top down
//  the sweep reads one table entry per cycle while the output is not stalled
//  reset clears the control state and the count; the table needs no clearing
//  a stalled output holds the sweep in place; the result register frees input
//
module row_cut_by_blockage_intervals import rcbi_pkg::*; #(
    parameter int MAX_BLOCKAGES = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CfgIdxW-1:0]        cfg_index,
    input  logic [CoordW-1:0]         cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [CoordW-1:0]  halo_left,
    input  logic signed [CoordW-1:0]  halo_bottom,
    input  logic signed [CoordW-1:0]  halo_right,
    input  logic signed [CoordW-1:0]  halo_top,
    input  logic                      has_macro,
    input  logic                      last_macro,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [CoordW-1:0]  seg_start,
    output logic signed [CoordW-1:0]  seg_end,
    output logic [IdxW-1:0]           seg_index,
    output logic                      row_empty,
    output logic                      dropped,
    output logic                      last_seg
);

    localparam int AW = (MAX_BLOCKAGES > 1) ? $clog2(MAX_BLOCKAGES) : 1;
    localparam int CW = $clog2(MAX_BLOCKAGES + 1);

    // configuration
    logic signed [CoordW-1:0] row_left_reg, row_right_reg, row_bottom_reg;
    logic signed [CoordW-1:0] row_top_reg, grid_origin_reg;
    logic [PitchW-1:0]        site_pitch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_left_reg    <= '0;
            row_right_reg   <= '0;
            row_bottom_reg  <= '0;
            row_top_reg     <= '0;
            grid_origin_reg <= '0;
            site_pitch_reg  <= PitchW'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_LEFT:    row_left_reg    <= cfg_wdata;
                REG_ROW_RIGHT:   row_right_reg   <= cfg_wdata;
                REG_ROW_BOTTOM:  row_bottom_reg  <= cfg_wdata;
                REG_ROW_TOP:     row_top_reg     <= cfg_wdata;
                REG_GRID_ORIGIN: grid_origin_reg <= cfg_wdata;
                REG_SITE_PITCH:  site_pitch_reg  <= cfg_wdata[PitchW-1:0];
                default: ;
            endcase
        end
    end

    // state
    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic                     last_reg, last_next;
    logic signed [CoordW-1:0] hl_reg, hr_reg;
    blk_t                     blk_reg, blk_next;
    logic [AW-1:0]            ptr_reg, ptr_next;
    logic signed [CoordW-1:0] cur_reg, cur_next;
    logic [IdxW-1:0]          idx_reg, idx_next;
    seg_t                     pend_reg, pend_next;
    logic                     pend_v_reg, pend_v_next;
    seg_t                     out_reg, out_next;
    logic                     out_v_reg, out_v_next;
    logic                     out_dr_reg, out_dr_next, out_last_reg, out_last_next;

    // memory and snap unit
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    blk_t          ram_wdata, ram_rdata;
    logic          mod_start, mod_done;
    logic [PitchW-1:0] mod_rl, mod_rr, pitch_eff;

    rcbi_ram #(
        .WIDTH($bits(blk_t)),
        .DEPTH(MAX_BLOCKAGES),
        .AW   (AW)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    rcbi_modu u_modu (
        .clk  (clk),
        .rst_n(rst_n),
        .start(mod_start),
        .dl   ((CoordW+2)'(halo_left) - (CoordW+2)'(grid_origin_reg)),
        .dr   ((CoordW+2)'(halo_right) - (CoordW+2)'(grid_origin_reg)),
        .pitch(site_pitch_reg),
        .done (mod_done),
        .rl   (mod_rl),
        .rr   (mod_rr)
    );

    assign pitch_eff = (site_pitch_reg == '0) ? PitchW'(1) : site_pitch_reg;

    logic accept, overlap, out_free, can_push;
    logic signed [CoordW+1:0] s_snap, e_snap;
    logic signed [CoordW-1:0] s_clip, e_clip;
    logic skip, need_emit, at_end;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign overlap  = has_macro && (halo_top > row_bottom_reg)
                      && (halo_bottom < row_top_reg);
    assign out_free = !out_v_reg || out_ready;
    assign can_push = !pend_v_reg || out_free;

    // snap outward then clip to the row
    assign s_snap = (CoordW+2)'(hl_reg) - (CoordW+2)'(mod_rl);
    assign e_snap = (CoordW+2)'(hr_reg)
                    + ((mod_rr == '0) ? '0 : (CoordW+2)'(pitch_eff - mod_rr));
    assign s_clip = (s_snap < (CoordW+2)'(row_left_reg)) ? row_left_reg
                    : s_snap[CoordW-1:0];
    assign e_clip = (e_snap > (CoordW+2)'(row_right_reg)) ? row_right_reg
                    : e_snap[CoordW-1:0];

    assign skip      = ram_rdata.hi <= cur_reg;
    assign need_emit = !skip && (ram_rdata.lo > cur_reg);
    assign at_end    = (CW'(ptr_reg) + 1'b1) == count_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (overlap)
                        state_next = ST_SNAP;
                    else if (last_macro)
                        state_next = ST_SW_RD;
                end
            end
            ST_SNAP:
            begin
                if (mod_done)
                    state_next = ST_CLIP;
            end
            ST_CLIP:
            begin
                if (s_clip < e_clip && count_reg < CW'(MAX_BLOCKAGES)
                    && count_reg != '0)
                    state_next = ST_INS_CMP;
                else
                    state_next = last_reg ? ST_SW_RD : ST_IDLE;
            end
            ST_INS_CMP:
            begin
                if (ram_rdata.lo > blk_reg.lo && ptr_reg == '0)
                    state_next = ST_INS_PUT;
                else if (!(ram_rdata.lo > blk_reg.lo))
                    state_next = last_reg ? ST_SW_RD : ST_IDLE;
            end
            ST_INS_PUT:
            begin
                state_next = last_reg ? ST_SW_RD : ST_IDLE;
            end
            ST_SW_RD:
            begin
                state_next = (count_reg == '0) ? ST_FIN : ST_SW_CHK;
            end
            ST_SW_CHK:
            begin
                if (!(need_emit && !can_push))
                begin
                    if (!skip && ram_rdata.hi >= row_right_reg)
                        state_next = ST_FIN;
                    else if (at_end)
                        state_next = ST_SW_TAIL;
                end
            end
            ST_SW_TAIL:
            begin
                if (!(cur_reg < row_right_reg) || can_push)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        seg_t nseg;
        logic push;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        last_next     = last_reg;
        blk_next      = blk_reg;
        ptr_next      = ptr_reg;
        cur_next      = cur_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_v_next   = pend_v_reg;
        out_next      = out_reg;
        out_v_next    = out_v_reg && !out_ready;
        out_dr_next   = out_dr_reg;
        out_last_next = out_last_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = blk_reg;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        mod_start     = 1'b0;
        push          = 1'b0;
        nseg          = '{seg_start: cur_reg, seg_end: row_right_reg,
                          seg_index: idx_reg, row_empty: 1'b0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = last_macro;
                    mod_start = overlap;
                end
            end
            ST_SNAP: ;
            ST_CLIP:
            begin
                blk_next = '{lo: s_clip, hi: e_clip};
                if (s_clip < e_clip)
                begin
                    if (count_reg >= CW'(MAX_BLOCKAGES))
                        ovf_next = 1'b1;
                    else if (count_reg == '0)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = '0;
                        ram_wdata  = '{lo: s_clip, hi: e_clip};
                        count_next = CW'(1);
                    end
                    else
                    begin
                        // walk down from the top entry
                        ptr_next  = AW'(count_reg - 1'b1);
                        ram_re    = 1'b1;
                        ram_raddr = AW'(count_reg - 1'b1);
                    end
                end
            end
            ST_INS_CMP:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg + 1'b1;
                if (ram_rdata.lo > blk_reg.lo)
                begin
                    ram_wdata = ram_rdata;
                    if (ptr_reg != '0)
                    begin
                        ptr_next  = ptr_reg - 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = ptr_reg - 1'b1;
                    end
                end
                else
                begin
                    ram_wdata  = blk_reg;
                    count_next = count_reg + 1'b1;
                end
            end
            ST_INS_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = blk_reg;
                count_next = count_reg + 1'b1;
            end
            ST_SW_RD:
            begin
                cur_next = row_left_reg;
                idx_next = '0;
                ptr_next = '0;
                if (count_reg == '0)
                begin
                    pend_next   = '{seg_start: row_left_reg, seg_end: row_right_reg,
                                    seg_index: '0, row_empty: 1'b0};
                    pend_v_next = 1'b1;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                end
            end
            ST_SW_CHK:
            begin
                if (!(need_emit && !can_push))
                begin
                    if (need_emit)
                    begin
                        push          = 1'b1;
                        nseg.seg_end  = ram_rdata.lo;
                        idx_next      = idx_reg + 1'b1;
                    end
                    if (!skip)
                        cur_next = ram_rdata.hi;
                    if ((skip || ram_rdata.hi < row_right_reg) && !at_end)
                    begin
                        ptr_next  = ptr_reg + 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = ptr_reg + 1'b1;
                    end
                end
            end
            ST_SW_TAIL:
            begin
                if (cur_reg < row_right_reg && can_push)
                    push = 1'b1;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_next      = pend_v_reg ? pend_reg
                                    : '{seg_start: '0, seg_end: '0,
                                        seg_index: '0, row_empty: 1'b1};
                    out_v_next    = 1'b1;
                    out_dr_next   = ovf_reg;
                    out_last_next = 1'b1;
                    pend_v_next   = 1'b0;
                    count_next    = '0;
                    ovf_next      = 1'b0;
                end
            end
            default: ;
        endcase

        // a new segment pushes the held one out, so last_seg is known in time
        if (push)
        begin
            if (pend_v_reg)
            begin
                out_next      = pend_reg;
                out_v_next    = 1'b1;
                out_dr_next   = ovf_reg;
                out_last_next = 1'b0;
            end
            pend_next   = nseg;
            pend_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hl_reg <= halo_left;
            hr_reg <= halo_right;
        end
        last_reg     <= last_next;
        blk_reg      <= blk_next;
        ptr_reg      <= ptr_next;
        cur_reg      <= cur_next;
        idx_reg      <= idx_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_dr_reg   <= out_dr_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_v_reg;
    assign seg_start = out_reg.seg_start;
    assign seg_end   = out_reg.seg_end;
    assign seg_index = out_reg.seg_index;
    assign row_empty = out_reg.row_empty;
    assign dropped   = out_dr_reg;
    assign last_seg  = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_BLOCKAGES))
        else $error("blockage count above table capacity");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_v_reg)
        else $error("segment left held after the sweep");

    a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> state_reg == ST_SNAP)
        else $error("snap unit finished outside its wait state");

    a_ins_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == ST_INS_CMP) |-> (CW'(ram_waddr) <= count_reg))
        else $error("insert write beyond the filled part of the table");

endmodule
